// ===== hw/rtl/gdf_pkg.sv =====
// ----------------------------------------------------------------------------
// gdf_pkg
// Types and constants shared by the group diversity filter modules.
// ----------------------------------------------------------------------------
package gdf_pkg;

	// Field and register widths
	localparam int KEY_W    = 64;
	localparam int GCNT_W   = 16;
	localparam int TOTAL_W  = 32;
	localparam int CUTOFF_W = 11;
	localparam int CFG_W    = 32;
	localparam int CFG_IX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_MAX_TOTAL     = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_MAX_PER_GROUP = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_GROUP_CUTOFF  = 2'd2;
	localparam logic [CFG_IX_W-1:0] CFG_STRICT_CUTOFF = 2'd3;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_RESP
	} gdf_state_t;

	// Status of the table scan
	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

endpackage

// ===== hw/rtl/gdf_ram.sv =====
// ----------------------------------------------------------------------------
// gdf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/gdf_scan.sv =====
// ----------------------------------------------------------------------------
// gdf_scan
// Walks the filled part of the group memory, one read issued per cycle,
// and compares each returned key with the offered key.
// ----------------------------------------------------------------------------
module gdf_scan import gdf_pkg::*; #(
	parameter int TABLE_GROUPS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [KEY_W-1:0]     key,
	input  logic [$clog2(TABLE_GROUPS+1)-1:0] fill,
	input  logic [KEY_W-1:0]     rd_key,
	output logic                 rd_en,
	output logic [$clog2(TABLE_GROUPS > 1 ? TABLE_GROUPS : 2)-1:0] rd_addr,
	output logic [$clog2(TABLE_GROUPS > 1 ? TABLE_GROUPS : 2)-1:0] slot,
	output scan_stat_t           stat
);

	localparam int IDX_W = $clog2(TABLE_GROUPS > 1 ? TABLE_GROUPS : 2);
	localparam int CNT_W = $clog2(TABLE_GROUPS + 1);

	logic             busy_q;
	logic [CNT_W-1:0] next_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pend_idx_s1;
	logic             match;
	logic             more;

	// Compare the returned entry and decide whether to keep reading
	assign match   = busy_q && pend_s1 && (rd_key == key);
	assign more    = next_q < fill;
	assign rd_en   = busy_q && !match && more;
	assign rd_addr = next_q[IDX_W-1:0];
	assign slot    = pend_idx_s1;

	always_comb begin
		stat.done = busy_q && (match || !more);
		stat.hit  = match;
	end

	// Advance the read pointer and track the outstanding read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			next_q  <= '0;
			pend_s1 <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			next_q  <= '0;
			pend_s1 <= 1'b0;
		end else if (busy_q) begin
			pend_s1 <= rd_en;
			if (rd_en) begin
				next_q <= next_q + CNT_W'(1);
			end
			if (stat.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remember which entry the outstanding read addresses
	always_ff @(posedge clk) begin
		if (rd_en) begin
			pend_idx_s1 <= rd_addr;
		end
	end

endmodule

// ===== hw/rtl/group_diversity_filter_unit.sv =====
// ----------------------------------------------------------------------------
// group_diversity_filter_unit
// Accept/reject filter that limits hits per group key and in total, with
// the group keys and their counts held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_ready  | group_key
//  out     | out_valid / out_ready| accept, total_accepted
//  cfg     | cfg_we               | cfg_index, cfg_wdata
//
//  An item that needs no lookup goes straight to the result; one that looks
//  its group up waits on the linear scan of the group memory
//  (one read port, one entry per cycle). The memory needs no clearing
//  after reset: only entries below the fill count are ever read. A stalled
//  output holds the finished result in its register while the next item
//  may already be taken.
// ----------------------------------------------------------------------------
module group_diversity_filter_unit import gdf_pkg::*; #(
	parameter int TABLE_GROUPS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [KEY_W-1:0]     group_key,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 accept,
	output logic [TOTAL_W-1:0]   total_accepted,
	input  logic                 cfg_we,
	input  logic [CFG_IX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_GROUPS > 1 ? TABLE_GROUPS : 2);
	localparam int CNT_W = $clog2(TABLE_GROUPS + 1);
	localparam int CMP_W = (CNT_W > CUTOFF_W) ? CNT_W : CUTOFF_W;
	localparam int ENT_W = KEY_W + GCNT_W;

	// Configuration
	logic [TOTAL_W-1:0]  max_total_q;
	logic [GCNT_W-1:0]   max_per_group_q;
	logic [CUTOFF_W-1:0] group_cutoff_q;
	logic                strict_q;

	// Control and item state
	gdf_state_t          state_q, state_d;
	logic [KEY_W-1:0]    key_q;
	logic                insert_q;
	logic [CNT_W-1:0]    groups_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                acc_q;
	logic                hit_q;
	logic [IDX_W-1:0]    slot_q;
	logic [GCNT_W-1:0]   count_q;
	logic                out_valid_q;
	logic                out_acc_q;
	logic [TOTAL_W-1:0]  out_total_q;

	// Decode and interface signals
	logic                in_xfer;
	logic                out_load;
	logic                scan_start;
	logic                over_total;
	logic                below_cut;
	logic [CMP_W-1:0]    cut_ext;
	logic [CMP_W-1:0]    groups_ext;
	logic                room;

	// Memory and scan signals
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ENT_W-1:0]    ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [ENT_W-1:0]    ram_rdata;
	logic [IDX_W-1:0]    scan_slot;
	scan_stat_t          scan_stat;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q     <= '0;
			max_per_group_q <= '0;
			group_cutoff_q  <= '0;
			strict_q        <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_TOTAL:     max_total_q     <= cfg_wdata[TOTAL_W-1:0];
				CFG_MAX_PER_GROUP: max_per_group_q <= cfg_wdata[GCNT_W-1:0];
				CFG_GROUP_CUTOFF:  group_cutoff_q  <= cfg_wdata[CUTOFF_W-1:0];
				CFG_STRICT_CUTOFF: strict_q        <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Classify the offered item against the limits
	always_comb begin
		if (CMP_W'(group_cutoff_q) < CMP_W'(TABLE_GROUPS)) begin
			cut_ext = CMP_W'(group_cutoff_q);
		end else begin
			cut_ext = CMP_W'(TABLE_GROUPS);
		end
		groups_ext = CMP_W'(groups_q);
		below_cut  = groups_ext < cut_ext;
		over_total = total_q >= max_total_q;
		room       = count_q < max_per_group_q;
	end

	assign in_xfer = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (!over_total && (below_cut || strict_q)) ? ST_SCAN : ST_RESP;
				end
			end
			ST_SCAN: begin
				if (scan_stat.done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_RESP;
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_ready   = state_q == ST_IDLE;
		scan_start = 1'b0;
		out_load   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = slot_q;
		ram_wdata  = {key_q, count_q + GCNT_W'(1)};
		case (state_q)
			ST_IDLE: scan_start = in_xfer && !over_total && (below_cut || strict_q);
			ST_UPDATE: begin
				if (hit_q) begin
					ram_we = room;
				end else if (insert_q) begin
					ram_we    = 1'b1;
					ram_waddr = groups_q[IDX_W-1:0];
					ram_wdata = {key_q, (max_per_group_q != '0) ? GCNT_W'(1) : GCNT_W'(0)};
				end
			end
			ST_RESP: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Update item state, fill count and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_q <= '0;
			total_q  <= '0;
			acc_q    <= 1'b0;
			insert_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						insert_q <= below_cut;
						if (over_total) begin
							acc_q <= 1'b0;
						end else if (!below_cut && !strict_q) begin
							acc_q   <= 1'b1;
							total_q <= total_q + TOTAL_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (scan_stat.done) begin
						hit_q <= scan_stat.hit;
					end
				end
				ST_UPDATE: begin
					if (hit_q) begin
						acc_q <= room;
						if (room) begin
							total_q <= total_q + TOTAL_W'(1);
						end
					end else if (insert_q) begin
						groups_q <= groups_q + CNT_W'(1);
						acc_q    <= max_per_group_q != '0;
						if (max_per_group_q != '0) begin
							total_q <= total_q + TOTAL_W'(1);
						end
					end else begin
						// unseen group after cutoff in strict mode: pass without storing
						acc_q   <= 1'b1;
						total_q <= total_q + TOTAL_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the key and the found entry
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q <= group_key;
		end
		if (state_q == ST_SCAN && scan_stat.done) begin
			slot_q  <= scan_slot;
			count_q <= ram_rdata[GCNT_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_acc_q   <= acc_q;
			out_total_q <= total_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign accept         = out_acc_q;
	assign total_accepted = out_total_q;

	// Group memory: key and count per entry
	gdf_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_GROUPS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	gdf_scan #(
		.TABLE_GROUPS(TABLE_GROUPS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.key    (key_q),
		.fill   (groups_q),
		.rd_key (ram_rdata[ENT_W-1:GCNT_W]),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.slot   (scan_slot),
		.stat   (scan_stat)
	);

endmodule

// ===== sim/gdf_hit_checker.sv =====
// ----------------------------------------------------------------------------
// gdf_hit_checker
// Watches the hit, result and register ports of the group diversity filter.
// It keeps its own copy of the group table, the running total and the
// limits, works out the verdict for each hit taken, and compares it with
// each result delivered, oldest first.
// ----------------------------------------------------------------------------
module gdf_hit_checker import gdf_pkg::*; #(
	parameter int TABLE_GROUPS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [KEY_W-1:0]    group_key,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                accept,
	input  logic [TOTAL_W-1:0]  total_accepted,
	input  logic                cfg_we,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                closing,
	output int                  fail_count,
	output int                  pending,
	output logic [TOTAL_W-1:0]  model_total,
	output int                  model_groups
);

	typedef struct packed {
		logic               acc;
		logic [TOTAL_W-1:0] total;
	} hit_verdict_t;

	localparam int NO_SLOT = -1;

	// Group table: entries below groups_seen are filled
	logic [KEY_W-1:0]    key_tbl [TABLE_GROUPS];
	logic [GCNT_W-1:0]   cnt_tbl [TABLE_GROUPS];
	int                  groups_seen;
	logic [TOTAL_W-1:0]  hits_total;

	// Limits as last written
	logic [TOTAL_W-1:0]  lim_total;
	logic [GCNT_W-1:0]   lim_per_group;
	logic [CUTOFF_W-1:0] lim_cutoff;
	logic                lim_strict;

	hit_verdict_t        verdict_q[$];
	bit                  leftover_checked;

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want, got);
		fail_count++;
	endtask

	function automatic int find_group(input logic [KEY_W-1:0] key);
		for (int i = 0; i < groups_seen; i++) begin
			if (key_tbl[i] == key)
				return i;
		end
		return NO_SLOT;
	endfunction

	// Count one more hit against a stored group if it has room left
	function automatic logic take_from_group(input int slot);
		if (cnt_tbl[slot] < lim_per_group) begin
			cnt_tbl[slot] = cnt_tbl[slot] + GCNT_W'(1);
			hits_total = hits_total + TOTAL_W'(1);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic hit_verdict_t judge_hit(input logic [KEY_W-1:0] key);
		int           cut;
		int           slot;
		hit_verdict_t v;
		// Cutoff saturates at the table size
		cut = (int'(lim_cutoff) < TABLE_GROUPS) ? int'(lim_cutoff) : TABLE_GROUPS;
		v.acc = 1'b0;
		if (hits_total < lim_total) begin
			if (groups_seen < cut) begin
				slot = find_group(key);
				// Store a new group even if the hit ends up rejected
				if (slot == NO_SLOT) begin
					slot = groups_seen;
					key_tbl[slot] = key;
					cnt_tbl[slot] = '0;
					groups_seen++;
				end
				v.acc = take_from_group(slot);
			end else if (lim_strict) begin
				slot = find_group(key);
				if (slot == NO_SLOT) begin
					hits_total = hits_total + TOTAL_W'(1);
					v.acc = 1'b1;
				end else begin
					v.acc = take_from_group(slot);
				end
			end else begin
				hits_total = hits_total + TOTAL_W'(1);
				v.acc = 1'b1;
			end
		end
		v.total = hits_total;
		return v;
	endfunction

	// Track writes, predict each hit transfer, compare each result transfer
	always @(posedge clk or negedge arst_n) begin
		hit_verdict_t want;
		if (!arst_n) begin
			fail_count = 0;
			groups_seen = 0;
			hits_total = '0;
			lim_total = '0;
			lim_per_group = '0;
			lim_cutoff = '0;
			lim_strict = 1'b0;
			leftover_checked = 1'b0;
			verdict_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_TOTAL:     lim_total = cfg_wdata[TOTAL_W-1:0];
					CFG_MAX_PER_GROUP: lim_per_group = cfg_wdata[GCNT_W-1:0];
					CFG_GROUP_CUTOFF:  lim_cutoff = cfg_wdata[CUTOFF_W-1:0];
					CFG_STRICT_CUTOFF: lim_strict = cfg_wdata[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result with no hit waiting", '0, 64'(total_accepted));
				end else begin
					want = verdict_q.pop_front();
					if (accept !== want.acc)
						report_mismatch("accept", 64'(want.acc), 64'(accept));
					if (total_accepted !== want.total)
						report_mismatch("total_accepted", 64'(want.total),
							64'(total_accepted));
				end
			end
			if (in_valid && in_ready)
				verdict_q.push_back(judge_hit(group_key));
			if (closing && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (verdict_q.size() != 0)
					report_mismatch("results never delivered", '0, 64'(verdict_q.size()));
			end
		end
		pending = verdict_q.size();
		model_total = hits_total;
		model_groups = groups_seen;
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives hits and limit settings into the group diversity filter under
// several idling patterns: a directed opening on the limit and cutoff
// corner cases, random phases over reused and fresh keys, a fill of the
// whole group table past a saturated cutoff, and a strict pass on the full
// table. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench;
	import gdf_pkg::*;

	localparam int TABLE_GROUPS = 1024;
	localparam int STALL_LIMIT  = 20000;
	localparam int PHASE_ITEMS  = 100;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [KEY_W-1:0]    group_key;
	logic                out_valid;
	logic                out_ready;
	logic                accept;
	logic [TOTAL_W-1:0]  total_accepted;
	logic                cfg_we;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                closing;

	int                  fail_count;
	int                  pending;
	logic [TOTAL_W-1:0]  model_total;
	int                  model_groups;

	int                  send_idle;
	int                  recv_stall;
	int                  quiet_cycles = 0;
	logic [KEY_W-1:0]    seen_keys[$];

	group_diversity_filter_unit #(
		.TABLE_GROUPS(TABLE_GROUPS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.group_key(group_key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accept(accept),
		.total_accepted(total_accepted),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	gdf_hit_checker #(
		.TABLE_GROUPS(TABLE_GROUPS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.group_key(group_key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accept(accept),
		.total_accepted(total_accepted),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.closing(closing),
		.fail_count(fail_count),
		.pending(pending),
		.model_total(model_total),
		.model_groups(model_groups)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the result channel at random
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_stall);
		end
	end

	// End the run if nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("group_diversity_filter_unit verification failed");
			$finish;
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_idle = 0;  recv_stall = 0;  end
			IDLE_SENDER:   begin send_idle = 63; recv_stall = 0;  end
			IDLE_RECEIVER: begin send_idle = 0;  recv_stall = 63; end
			default:       begin send_idle = 8;  recv_stall = 8;  end
		endcase
	endtask

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		k = {$urandom, $urandom};
		seen_keys.push_back(k);
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] old_key();
		if (seen_keys.size() == 0)
			return fresh_key();
		return seen_keys[$urandom_range(seen_keys.size() - 1)];
	endfunction

	// Fill the bits above a register's width with noise
	function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int w);
		return (CFG_W'($urandom) & ~((CFG_W'(1) << w) - CFG_W'(1))) | v;
	endfunction

	// Offer one hit; called and returns at a falling edge
	task automatic offer_hit(input logic [KEY_W-1:0] key);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		group_key = key;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold the sender until every expected result has come out
	task automatic hold_until_drained();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = ix;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_limits(input logic [TOTAL_W-1:0] total, input logic [GCNT_W-1:0] per_group,
			input logic [CUTOFF_W-1:0] cutoff, input logic strict);
		hold_until_drained();
		write_reg(CFG_MAX_TOTAL, total);
		write_reg(CFG_MAX_PER_GROUP, with_junk(CFG_W'(per_group), GCNT_W));
		write_reg(CFG_GROUP_CUTOFF, with_junk(CFG_W'(cutoff), CUTOFF_W));
		write_reg(CFG_STRICT_CUTOFF, with_junk(CFG_W'(strict), 1));
	endtask

	// Mostly a small pool of repeating keys, half of them from earlier phases
	task automatic run_phase(input int n_items, input idle_mode_t mode);
		logic [KEY_W-1:0] hot_keys[16];
		int               r;
		for (int i = 0; i < 16; i++)
			hot_keys[i] = (i < 8) ? old_key() : fresh_key();
		set_idling(mode);
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				hold_until_drained();
			r = $urandom_range(99);
			if (r < 75)
				offer_hit(hot_keys[$urandom_range(15)]);
			else if (r < 80)
				offer_hit(r[0] ? '1 : '0);
			else
				offer_hit(fresh_key());
		end
	endtask

	initial begin
		int gs;
		arst_n = 1'b0;
		in_valid = 1'b0;
		group_key = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_TOTAL;
		cfg_wdata = '0;
		closing = 1'b0;
		set_idling(IDLE_NONE);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset limits: total limit zero rejects everything
		offer_hit('0);
		offer_hit('1);

		// Per-group limit of two, cutoff four; float -0 and +0 are distinct
		set_limits('1, 16'd2, 11'd4, 1'b0);
		offer_hit('0);
		offer_hit('0);
		offer_hit('0);
		offer_hit(64'h8000_0000_0000_0000);
		offer_hit('1);
		offer_hit(64'h5555_5555_5555_5555);
		offer_hit('0);
		offer_hit(64'hAAAA_AAAA_AAAA_AAAA);

		// Strict after cutoff: stored groups still limited, new ones pass
		set_limits('1, 16'd2, 11'd4, 1'b1);
		offer_hit('0);
		offer_hit('1);
		offer_hit('1);
		offer_hit(64'hAAAA_AAAA_AAAA_AAAA);
		offer_hit(64'hAAAA_AAAA_AAAA_AAAA);

		// Zero per-group limit: new groups are stored though rejected
		set_limits('1, 16'd0, 11'd6, 1'b1);
		offer_hit(64'd1);
		offer_hit(64'd1);
		offer_hit(64'd2);

		// Cutoff lowered below the groups already seen
		set_limits('1, 16'd1, 11'd2, 1'b1);
		offer_hit(64'd1);
		offer_hit(64'd1);
		offer_hit(64'd3);
		set_limits('1, 16'd1, 11'd2, 1'b0);
		offer_hit(64'd1);

		// Random phases with modest table growth
		for (int p = 0; p < 9; p++) begin
			gs = model_groups;
			case (p % 6)
				0: set_limits('1, GCNT_W'($urandom_range(1, 4)),
						CUTOFF_W'(gs + $urandom_range(1, 12)), 1'b0);
				1: set_limits('1, GCNT_W'($urandom_range(1, 4)),
						CUTOFF_W'(gs + $urandom_range(1, 12)), 1'b1);
				2: set_limits(model_total + TOTAL_W'($urandom_range(10, 60)), 16'hFFFF,
						CUTOFF_W'(gs + $urandom_range(1, 12)), 1'($urandom_range(1)));
				3: set_limits('1, 16'd0, CUTOFF_W'(gs + $urandom_range(1, 8)), 1'b1);
				4: set_limits($urandom, GCNT_W'($urandom_range(65535)), 11'd0, 1'b1);
				default: set_limits('1, GCNT_W'($urandom_range(1, 3)),
						CUTOFF_W'($urandom_range(gs)), 1'b1);
			endcase
			run_phase(PHASE_ITEMS, idle_mode_t'(p % 4));
		end

		// Fill the whole table under a cutoff above the table size
		set_limits('1, 16'hFFFF, 11'h7FF, 1'b0);
		set_idling(IDLE_BOTH);
		while (model_groups < TABLE_GROUPS)
			offer_hit(($urandom_range(9) == 0) ? old_key() : fresh_key());
		repeat (40)
			offer_hit($urandom_range(1) ? old_key() : fresh_key());

		// Strict on a full table
		set_limits('1, 16'd1, 11'h7FF, 1'b1);
		set_idling(IDLE_RECEIVER);
		repeat (20)
			offer_hit($urandom_range(1) ? old_key() : fresh_key());

		// Drain, let the block settle, then give the verdict
		hold_until_drained();
		repeat (model_groups + 8) @(negedge clk);
		closing = 1'b1;
		@(negedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("group_diversity_filter_unit verification clean");
		else
			$display("group_diversity_filter_unit verification failed");
		$finish;
	end

endmodule
